FILE: rtl/control_capture_detector_unit_assert.svh
// Assertion macros for the control capture detector.
`ifndef CONTROL_CAPTURE_DETECTOR_UNIT_ASSERT_SVH
`define CONTROL_CAPTURE_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("control capture detector: check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("control capture detector: check failed");

`endif

FILE: rtl/ccd_pkg.sv
// Types and constants shared by the control capture detector modules.
`default_nettype none

package ccd_pkg;

  // Opcodes
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_FEED   = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;

  // Control kinds
  localparam logic [2:0] KIND_AXIS       = 3'd0;
  localparam logic [2:0] KIND_TRIGGER    = 3'd1;
  localparam logic [2:0] KIND_BUTTON     = 3'd2;
  localparam logic [2:0] KIND_HAT_UP     = 3'd3;
  localparam logic [2:0] KIND_HAT_DOWN   = 3'd4;
  localparam logic [2:0] KIND_HAT_LEFT   = 3'd5;
  localparam logic [2:0] KIND_HAT_RIGHT  = 3'd6;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVATE = 2'd1;

  localparam int unsigned THRESH_W = 16;
  localparam logic [THRESH_W-1:0] RELEASE_RESET  = 16'd8192;
  localparam logic [THRESH_W-1:0] ACTIVATE_RESET = 16'd16384;

  // Activation is Q1.15 carried signed with headroom for full-on and trigger pulls
  localparam int unsigned ACT_W = 18;
  localparam logic signed [ACT_W-1:0] FULL_ON  = 18'sd32768;
  localparam logic signed [ACT_W-1:0] AXIS_MAX = 18'sd32767;

  localparam int unsigned POS_W = 7;
  localparam logic [POS_W-1:0] POS_MAX = 7'd127;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         control_kind;
    logic [4:0]         control_number;
    logic signed [15:0] raw_reading;
    logic               last_of_sample;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [2:0] found_kind;
    logic [4:0] found_number;
    logic       found_negative;
    logic       still_waiting;
  } out_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] number;
    logic       negative;
  } hit_t;

  typedef struct packed {
    logic waiting;
    logic hit;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/ccd_activation.sv
// Activation of one control reading in Q1.15, with the axis direction.
`default_nettype none

module ccd_activation
  import ccd_pkg::*;
#(
  parameter int unsigned AXIS_COUNT    = 8,
  parameter int unsigned TRIGGER_COUNT = 2,
  parameter int unsigned BUTTON_COUNT  = 32,
  parameter int unsigned HAT_COUNT     = 4
) (
  input  wire logic [2:0]              kind,
  input  wire logic [4:0]              number,
  input  wire logic signed [15:0]      raw,
  output logic signed [ACT_W-1:0]      act,
  output logic                         negative
);

  logic signed [ACT_W-1:0] raw_ext;
  logic signed [ACT_W-1:0] magnitude;
  logic [5:0]              num_ext;
  logic [1:0]              hat_bit;

  assign raw_ext = ACT_W'(raw);
  assign num_ext = {1'b0, number};
  assign hat_bit = 2'(kind - KIND_HAT_UP);

  always_comb begin
    act       = '0;
    negative  = 1'b0;
    magnitude = raw[15] ? -raw_ext : raw_ext;
    unique case (kind)
      KIND_AXIS: begin
        if (num_ext < 6'(AXIS_COUNT)) begin
          negative = raw[15];
          act      = (magnitude > AXIS_MAX) ? AXIS_MAX : magnitude;
        end
      end
      KIND_TRIGGER: begin
        if (num_ext < 6'(TRIGGER_COUNT)) act = raw_ext;
      end
      KIND_BUTTON: begin
        if (num_ext < 6'(BUTTON_COUNT) && raw != 16'sd0) act = FULL_ON;
      end
      KIND_HAT_UP, KIND_HAT_DOWN, KIND_HAT_LEFT, KIND_HAT_RIGHT: begin
        if (num_ext < 6'(HAT_COUNT) && raw[hat_bit]) act = FULL_ON;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/ccd_tracker.sv
// Candidate list, arm bits and first-hit tracking; one item per cycle while go is high.
`default_nettype none

module ccd_tracker
  import ccd_pkg::*;
#(
  parameter int unsigned MAX_CANDIDATES = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    go,
  input  wire in_item_t                item,
  input  wire logic signed [ACT_W-1:0] act,
  input  wire logic                    negative,
  input  wire logic [THRESH_W-1:0]     release_threshold,
  input  wire logic [THRESH_W-1:0]     activate_threshold,
  output logic                         emit,
  output out_item_t                    result,
  output status_t                      status
);

  localparam int unsigned IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

  logic [MAX_CANDIDATES-1:0] armed, armed_next;
  logic                      waiting, waiting_next;
  logic [POS_W-1:0]          position, position_next;
  logic [POS_W-1:0]          total, total_next;
  logic                      hit, hit_next;
  hit_t                      record, record_next;

  logic             at_rest, active;
  logic             in_list;
  logic [IDX_W-1:0] idx;
  logic [POS_W-1:0] pos_adv;

  assign at_rest = act < $signed({2'b00, release_threshold});
  assign active  = act >= $signed({2'b00, activate_threshold});
  assign in_list = position < POS_W'(MAX_CANDIDATES);
  assign idx     = position[IDX_W-1:0];
  assign pos_adv = (position == POS_MAX) ? position : position + 7'd1;
  assign emit    = (item.opcode == OP_FEED) && item.last_of_sample;
  assign status  = '{waiting: waiting, hit: hit};

  always_comb begin
    armed_next    = armed;
    waiting_next  = waiting;
    position_next = position;
    total_next    = total;
    hit_next      = hit;
    record_next   = record;
    result        = '0;
    unique case (item.opcode)
      OP_CANCEL: begin
        armed_next    = '0;
        waiting_next  = 1'b0;
        position_next = '0;
        total_next    = '0;
        hit_next      = 1'b0;
        record_next   = '0;
      end
      OP_BEGIN: begin
        if (position == '0) begin
          armed_next = '0;
          total_next = '0;
        end
        if (in_list) begin
          armed_next[idx] = at_rest;
          total_next      = position + 7'd1;
        end
        position_next = pos_adv;
        if (item.last_of_sample) begin
          waiting_next  = 1'b1;
          position_next = '0;
          hit_next      = 1'b0;
          record_next   = '0;
        end
      end
      OP_FEED: begin
        if (waiting && position < total && in_list) begin
          if (!armed[idx]) begin
            armed_next[idx] = at_rest;
          end else if (!hit && active) begin
            hit_next    = 1'b1;
            record_next = '{kind: item.control_kind, number: item.control_number,
                            negative: negative};
          end
        end
        position_next = pos_adv;
        if (item.last_of_sample) begin
          // report the hit of this sample, then drop it
          result.found = waiting && hit_next;
          if (result.found) begin
            result.found_kind     = record_next.kind;
            result.found_number   = record_next.number;
            result.found_negative = record_next.negative;
          end
          waiting_next         = waiting && !result.found;
          result.still_waiting = waiting_next;
          position_next        = '0;
          hit_next             = 1'b0;
          record_next          = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= '0;
      waiting  <= 1'b0;
      position <= '0;
      total    <= '0;
      hit      <= 1'b0;
      record   <= '0;
    end else if (go) begin
      armed    <= armed_next;
      waiting  <= waiting_next;
      position <= position_next;
      total    <= total_next;
      hit      <= hit_next;
      record   <= record_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/control_capture_detector_unit.sv
// Top level of the control capture detector: handshakes, registers, checks.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one control reading per
//   item, in candidate-list order, with last_of_sample on the final reading of a
//   sample. A begin sample builds and arms the list, a feed sample looks for the
//   first armed control that crosses activate_threshold, cancel stops capture.
//   result channel (result_valid/result_ready/result) carries one item at the
//   end of each feed sample; begin, cancel and unmarked readings give none.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the release
//   (index 0) and activate (index 1) thresholds; cfg_ready is always high.
// Timing: an accepted item is captured in the input register; once it advances,
//   a sample end's result is loaded into the result register, which drives
//   result_valid. One item per cycle is sustained unless a sample end waits on
//   a full result register: the tracker updates all of its state as items advance.
// Reset: synchronous on rst; thresholds go to 8192 and 16384, the list is
//   emptied and capture is inactive. All arm bits clear in the reset cycle.
// Stall: while result_valid is held by a low result_ready, readings that give
//   no result still advance; a sample end waits in the input register and
//   item_ready drops until the result register frees.
`default_nettype none
`include "control_capture_detector_unit_assert.svh"

module control_capture_detector_unit
  import ccd_pkg::*;
#(
  parameter int unsigned MAX_CANDIDATES = 64,
  parameter int unsigned AXIS_COUNT     = 8,
  parameter int unsigned TRIGGER_COUNT  = 2,
  parameter int unsigned BUTTON_COUNT   = 32,
  parameter int unsigned HAT_COUNT      = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire in_item_t               item,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output out_item_t                   result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [THRESH_W-1:0]    cfg_data
);

  logic [THRESH_W-1:0] release_threshold;
  logic [THRESH_W-1:0] activate_threshold;

  // input register
  logic     hold_valid;
  in_item_t hold;

  logic                    advance;
  logic                    emit;
  out_item_t               result_next;
  status_t                 status;
  logic signed [ACT_W-1:0] act;
  logic                    negative;

  // Move the held item on unless it ends a sample and the result register is full
  assign advance    = hold_valid && (!emit || !result_valid || result_ready);
  assign item_ready = !hold_valid || advance;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_threshold  <= RELEASE_RESET;
      activate_threshold <= ACTIVATE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_RELEASE)  release_threshold  <= cfg_data;
      if (cfg_index == CFG_ACTIVATE) activate_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      hold <= item;
    end
  end

  ccd_activation #(
    .AXIS_COUNT    (AXIS_COUNT),
    .TRIGGER_COUNT (TRIGGER_COUNT),
    .BUTTON_COUNT  (BUTTON_COUNT),
    .HAT_COUNT     (HAT_COUNT)
  ) u_activation (
    .kind     (hold.control_kind),
    .number   (hold.control_number),
    .raw      (hold.raw_reading),
    .act      (act),
    .negative (negative)
  );

  ccd_tracker #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_tracker (
    .clk                (clk),
    .rst                (rst),
    .go                 (advance),
    .item               (hold),
    .act                (act),
    .negative           (negative),
    .release_threshold  (release_threshold),
    .activate_threshold (activate_threshold),
    .emit               (emit),
    .result             (result_next),
    .status             (status)
  );

  // result register: load on a sample end, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result <= result_next;
    end
  end

  `CCD_ASSERT_NOW(a_stall_blocks_input, hold_valid && !advance, !item_ready)
  `CCD_ASSERT_NEXT(a_sample_end_loads, advance && emit, result_valid)
  `CCD_ASSERT_NEXT(a_cancel_stops, advance && hold.opcode == OP_CANCEL,
                   !status.waiting && !status.hit)
  `CCD_ASSERT_NEXT(a_found_ends_capture, advance && emit && result_next.found,
                   !status.waiting && !result.still_waiting)

endmodule

`default_nettype wire

FILE: test/control_capture_detector_unit_test.sv
// Self-checking testbench of the control capture detector: directed rows, then random samples.
`timescale 1ns / 100ps

module control_capture_detector_unit_test;
  import ccd_pkg::*;

  // Sizes of the instance under test; the tracker below mirrors them.
  localparam int MAX_CANDIDATES = 64;
  localparam int AXIS_COUNT     = 8;
  localparam int TRIGGER_COUNT  = 2;
  localparam int BUTTON_COUNT   = 32;
  localparam int HAT_COUNT      = 4;

  // Codes the package leaves unnamed: the spare opcode and the eighth kind.
  localparam logic [1:0] OP_SPARE  = 2'd3;
  localparam logic [2:0] KIND_NONE = 3'd7;

  localparam int ITEM_GOAL   = 1900;
  localparam int PHASE_COUNT = 6;
  localparam int SETTLE      = 8;   // cycles to let a begin or cancel item retire
  localparam int LONG_HOLD   = 150; // receiver hold-off, in cycles

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_ready;
  in_item_t   item;
  logic       result_valid;
  logic       result_ready;
  out_item_t  result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [THRESH_W-1:0]    cfg_data;

  // A directed row may carry a hand-written result; it rides along with the item.
  logic       pinned;
  out_item_t  pin_value;

  int errors;
  int items_sent;
  bit brisk; // sender offers back to back while set

  control_capture_detector_unit #(
    .MAX_CANDIDATES(MAX_CANDIDATES),
    .AXIS_COUNT    (AXIS_COUNT),
    .TRIGGER_COUNT (TRIGGER_COUNT),
    .BUTTON_COUNT  (BUTTON_COUNT),
    .HAT_COUNT     (HAT_COUNT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Capture tracker: our own copy of the thresholds and the candidate list.
  // ---------------------------------------------------------------------------
  logic [THRESH_W-1:0] release_thr;
  logic [THRESH_W-1:0] activate_thr;
  bit   armed [MAX_CANDIDATES];
  bit   capture_on;
  int   run_pos;
  int   list_len;
  bit   hit_seen;
  hit_t first_hit;

  out_item_t pending_results [$];

  // Drop the list, the run position and any hit (reset and cancel).
  function automatic void clear_tracker();
    armed      = '{default: 1'b0};
    capture_on = 1'b0;
    run_pos    = 0;
    list_len   = 0;
    hit_seen   = 1'b0;
    first_hit  = '0;
  endfunction

  // Advance the tracker by one reading; return 1 when the reading ends a feed
  // sample, with the report in res.
  function automatic bit capture_step(input in_item_t it, output out_item_t res);
    int v;
    int act;
    bit neg;
    bit found;
    v   = int'($signed(it.raw_reading));
    act = 0;
    neg = 1'b0;
    res = '0;
    // Work out the activation in Q1.15; an index past its kind's count reads zero.
    case (it.control_kind)
      KIND_AXIS: begin
        if (it.control_number < AXIS_COUNT) begin
          neg = v < 0;
          act = (v < 0) ? -v : v;
          if (act > 32767) act = 32767;
        end
      end
      KIND_TRIGGER: begin
        if (it.control_number < TRIGGER_COUNT) act = v;
      end
      KIND_BUTTON: begin
        if (it.control_number < BUTTON_COUNT)
          act = (it.raw_reading != 0) ? int'(FULL_ON) : 0;
      end
      KIND_HAT_UP, KIND_HAT_DOWN, KIND_HAT_LEFT, KIND_HAT_RIGHT: begin
        if (it.control_number < HAT_COUNT)
          act = it.raw_reading[it.control_kind - KIND_HAT_UP] ? int'(FULL_ON) : 0;
      end
      default: act = 0;
    endcase

    case (it.opcode)
      OP_CANCEL: begin
        clear_tracker();
        return 1'b0;
      end
      OP_SPARE: return 1'b0;
      OP_BEGIN: begin
        // The first baseline reading of a run starts a fresh list.
        if (run_pos == 0) begin
          armed    = '{default: 1'b0};
          list_len = 0;
        end
        if (run_pos < MAX_CANDIDATES) begin
          armed[run_pos] = act < int'(release_thr);
          list_len       = run_pos + 1;
        end
        if (run_pos < POS_MAX) run_pos++;
        if (it.last_of_sample) begin
          capture_on = 1'b1;
          run_pos    = 0;
          hit_seen   = 1'b0;
          first_hit  = '0;
        end
        return 1'b0;
      end
      default: ;
    endcase

    // Feed reading: arm at rest, else keep the first armed control that fires.
    if (capture_on && run_pos < list_len && run_pos < MAX_CANDIDATES) begin
      if (!armed[run_pos]) begin
        armed[run_pos] = act < int'(release_thr);
      end else if (!hit_seen && act >= int'(activate_thr)) begin
        hit_seen           = 1'b1;
        first_hit.kind     = it.control_kind;
        first_hit.number   = it.control_number;
        first_hit.negative = neg;
      end
    end
    if (run_pos < POS_MAX) run_pos++;
    if (!it.last_of_sample) return 1'b0;

    found = capture_on && hit_seen;
    if (found) begin
      capture_on         = 1'b0;
      res.found          = 1'b1;
      res.found_kind     = first_hit.kind;
      res.found_number   = first_hit.number;
      res.found_negative = first_hit.negative;
    end
    res.still_waiting = capture_on;
    run_pos   = 0;
    hit_seen  = 1'b0;
    first_hit = '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: sample every handshake at the edge where it completes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    out_item_t predicted;
    out_item_t want;
    bit        gives;
    if (rst) begin
      clear_tracker();
      release_thr  = RELEASE_RESET;
      activate_thr = ACTIVATE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RELEASE:  release_thr  = cfg_data;
          CFG_ACTIVATE: activate_thr = cfg_data;
          default: ;
        endcase
      end
      // Retire the result first: it always belongs to an earlier item.
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result expected none got %h", $time, result);
        end else begin
          want = pending_results.pop_front();
          check_field("found", 8'(want.found), 8'(result.found));
          check_field("found_kind", 8'(want.found_kind), 8'(result.found_kind));
          check_field("found_number", 8'(want.found_number), 8'(result.found_number));
          check_field("found_negative", 8'(want.found_negative),
                      8'(result.found_negative));
          check_field("still_waiting", 8'(want.still_waiting),
                      8'(result.still_waiting));
        end
      end
      if (item_valid && item_ready) begin
        gives = capture_step(item, predicted);
        if (gives) pending_results = {pending_results, (pinned ? pin_value : predicted)};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls per item, calm stretches, and two long holds.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    int taken;
    int calm;
    taken = 0;
    calm  = 0;
    result_ready = 1'b0;
    forever begin
      if (taken == 25 || taken == 400) begin
        stall = LONG_HOLD; // hold off long enough for the block to back up
      end else if (calm > 0) begin
        stall = 0;
        calm--;
      end else if ($urandom_range(0, 15) == 0) begin
        calm  = $urandom_range(10, 40);
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Item side helpers.
  // ---------------------------------------------------------------------------
  function automatic in_item_t reading(input logic [1:0] op, input logic [2:0] k,
                                       input logic [4:0] n, input logic signed [15:0] raw,
                                       input logic last);
    in_item_t it;
    it.opcode         = op;
    it.control_kind   = k;
    it.control_number = n;
    it.raw_reading    = raw;
    it.last_of_sample = last;
    return it;
  endfunction

  // Offer one item after a random gap and hold it until accepted.
  task automatic send(input in_item_t it, input bit pin = 1'b0, input out_item_t want = '0);
    int gap;
    gap = brisk ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    pinned     <= pin;
    pin_value  <= want;
    do @(posedge clk); while (!item_ready);
    items_sent++;
  endtask

  // Stop offering, wait for every outstanding result, then let the block settle.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Pick a control, mostly within its kind's count.
  function automatic void pick(output logic [2:0] k, output logic [4:0] n);
    int lim;
    k = ($urandom_range(0, 19) == 0) ? KIND_NONE : 3'($urandom_range(0, 6));
    case (k)
      KIND_AXIS:    lim = AXIS_COUNT;
      KIND_TRIGGER: lim = TRIGGER_COUNT;
      KIND_BUTTON:  lim = BUTTON_COUNT;
      default:      lim = HAT_COUNT;
    endcase
    n = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, lim - 1));
  endfunction

  // Draw a raw reading for a kind; with rest set, lean towards a control at rest.
  function automatic logic signed [15:0] raw_value(input logic [2:0] k, input bit rest);
    int mag;
    if (rest && $urandom_range(0, 4) != 0) begin
      if (k == KIND_AXIS || k == KIND_TRIGGER) begin
        mag = $urandom_range(0, 3000);
        return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
      end
      return 16'sd0;
    end
    case ($urandom_range(0, 5))
      0: return 16'sd0;
      1: return 16'sh7fff;
      2: return 16'sh8000;
      3: return 16'($urandom());
      4: return (k == KIND_BUTTON) ? 16'sd1 : 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(8192, 32767));
    endcase
  endfunction

  logic [2:0] list_kind [140];
  logic [4:0] list_num  [140];

  // One capture: optional noise, a baseline sample, then a few feed samples.
  task automatic run_session();
    int len;
    int feeds;
    int flen;
    logic [2:0] k;
    logic [4:0] n;
    brisk = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        pick(k, n);
        send(reading(2'($urandom_range(0, 3)), k, n, 16'($urandom()), 1'($urandom_range(0, 1))));
      end
    end
    // Mostly short lists; now and then one past the candidate limit and the
    // position ceiling.
    len = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      pick(list_kind[i], list_num[i]);
      send(reading(OP_BEGIN, list_kind[i], list_num[i], raw_value(list_kind[i], 1'b1),
                   i == len - 1));
    end
    feeds = (len > 20) ? $urandom_range(1, 2) : $urandom_range(1, 6);
    for (int f = 0; f < feeds; f++) begin
      if ($urandom_range(0, 15) == 0) begin
        pick(k, n);
        send(reading(OP_CANCEL, k, n, 16'($urandom()), 1'($urandom_range(0, 1))));
        return;
      end
      flen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len + 3) : len;
      if (flen > 140) flen = 140;
      for (int i = 0; i < flen; i++) begin
        if (i < len) begin
          k = list_kind[i];
          n = list_num[i];
        end else begin
          pick(k, n);
        end
        send(reading(OP_FEED, k, n, raw_value(k, $urandom_range(0, 2) == 0), i == flen - 1));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows: reset thresholds 8192 / 16384 apply throughout.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t  it;
    bit        pin;
    out_item_t want;
  } row_t;

  row_t opening_rows [$];

  function automatic void add_row(input logic [1:0] op, input logic [2:0] k,
                                  input logic [4:0] n, input logic signed [15:0] raw,
                                  input logic last, input bit pin = 1'b0,
                                  input out_item_t want = '0);
    row_t r;
    r.it   = reading(op, k, n, raw, last);
    r.pin  = pin;
    r.want = want;
    opening_rows = {opening_rows, r};
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [THRESH_W-1:0] rel;
    logic [THRESH_W-1:0] act;
    errors       = 0;
    items_sent   = 0;
    brisk        = 1'b0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    pinned       = 1'b0;
    pin_value    = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_RELEASE;
    cfg_data     = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Feed while idle: counted, reports nothing found and not waiting.
    add_row(OP_FEED, KIND_AXIS, 5'd0, 16'sh7fff, 1'b1, 1'b1, '0);
    // Spare opcode: ignored, no result.
    add_row(OP_SPARE, KIND_BUTTON, 5'd5, 16'sd1, 1'b1);
    // Baseline of nine candidates; only the pressed hat down stays unarmed.
    add_row(OP_BEGIN, KIND_AXIS, 5'd0, 16'sd0, 1'b0);
    add_row(OP_BEGIN, KIND_TRIGGER, 5'd1, 16'sh8000, 1'b0);
    add_row(OP_BEGIN, KIND_BUTTON, 5'd31, 16'sd0, 1'b0);
    add_row(OP_BEGIN, KIND_HAT_UP, 5'd3, 16'sd0, 1'b0);
    add_row(OP_BEGIN, KIND_HAT_DOWN, 5'd0, 16'sh000e, 1'b0);
    add_row(OP_BEGIN, KIND_HAT_LEFT, 5'd0, 16'sh000b, 1'b0);
    add_row(OP_BEGIN, KIND_NONE, 5'd31, 16'sh7fff, 1'b0);
    add_row(OP_BEGIN, KIND_AXIS, 5'd8, 16'sh7fff, 1'b0);
    add_row(OP_BEGIN, KIND_HAT_UP, 5'd4, 16'shffff, 1'b1);
    // Full negative push on axis 0 wins; a later hit on axis 7 is not kept.
    add_row(OP_FEED, KIND_AXIS, 5'd0, 16'sh8000, 1'b0);
    add_row(OP_FEED, KIND_AXIS, 5'd7, 16'sh7fff, 1'b1, 1'b1,
            {1'b1, KIND_AXIS, 5'd0, 1'b1, 1'b0});
    // Button held from the start must not fire; trigger just short of the
    // threshold; hat down fires; a reading past the list is ignored.
    add_row(OP_BEGIN, KIND_BUTTON, 5'd0, 16'sd1, 1'b0);
    add_row(OP_BEGIN, KIND_TRIGGER, 5'd0, 16'sd0, 1'b0);
    add_row(OP_BEGIN, KIND_HAT_DOWN, 5'd3, 16'sd0, 1'b1);
    add_row(OP_FEED, KIND_BUTTON, 5'd0, 16'sd1, 1'b0);
    add_row(OP_FEED, KIND_TRIGGER, 5'd0, 16'sh3fff, 1'b0);
    add_row(OP_FEED, KIND_HAT_DOWN, 5'd3, 16'sh0002, 1'b0);
    add_row(OP_FEED, KIND_BUTTON, 5'd9, 16'sd1, 1'b1);
    // Cancel in the middle of a feed sample, then feed while idle.
    add_row(OP_BEGIN, KIND_HAT_RIGHT, 5'd1, 16'sh0007, 1'b1);
    add_row(OP_FEED, KIND_HAT_RIGHT, 5'd1, 16'sh0008, 1'b0);
    add_row(OP_CANCEL, KIND_TRIGGER, 5'd1, 16'sh7fff, 1'b0);
    add_row(OP_FEED, KIND_TRIGGER, 5'd1, 16'sh7fff, 1'b1, 1'b1, '0);
    // Mixed sample: the marked reading's opcode decides the end of the run.
    add_row(OP_BEGIN, KIND_AXIS, 5'd2, 16'sd0, 1'b0);
    add_row(OP_FEED, KIND_AXIS, 5'd2, 16'sh7fff, 1'b1);

    foreach (opening_rows[i]) send(opening_rows[i].it, opening_rows[i].pin, opening_rows[i].want);
    drain();

    // Random phases, each with its own pair of thresholds; extremes first.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin rel = 16'd0;     act = 16'd32768; end
        1: begin rel = 16'd32768; act = 16'd0;     end
        2: begin rel = 16'd32768; act = 16'd32768; end
        3: begin rel = 16'd0;     act = 16'd0;     end
        default: begin
          rel = 16'($urandom_range(0, 32768));
          act = 16'($urandom_range(0, 32768));
        end
      endcase
      // Write both registers while the block is idle.
      cfg_valid <= 1'b1;
      cfg_index <= CFG_RELEASE;
      cfg_data  <= rel;
      do @(posedge clk); while (!cfg_ready);
      cfg_index <= CFG_ACTIVATE;
      cfg_data  <= act;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;

      while (items_sent < (ph + 1) * ITEM_GOAL / PHASE_COUNT) begin
        run_session();
        // Now and then pause until everything outstanding has come back.
        if ($urandom_range(0, 39) == 0) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("control_capture_detector_unit_test: clean");
    end else begin
      $display("control_capture_detector_unit_test: errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("control_capture_detector_unit_test: errors");
    $finish;
  end

endmodule
